### hdl/sau_pkg.sv
// ----------------------------------------------------------------------------
// sau_pkg
// Shared types and constants of the security attribution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

  localparam int REGIONS_DEF = 8;   // default number of region entries
  localparam int ADDR_W      = 32;
  localparam int GRAN_BITS   = 5;   // 32-byte region granularity
  localparam int FLD_W       = ADDR_W - GRAN_BITS;
  localparam int IDX_IN_W    = 3;   // width of region_index field
  localparam int ATTR_W      = 2;
  localparam int CTRL_W      = 2;

  // attribute codes
  localparam logic [ATTR_W-1:0] ATTR_SECURE    = 2'd0;
  localparam logic [ATTR_W-1:0] ATTR_NONSECURE = 2'd1;
  localparam logic [ATTR_W-1:0] ATTR_NSC       = 2'd2;

  // request types
  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // configuration register indexes
  localparam logic CFG_TZ   = 1'b0;
  localparam logic CFG_CTRL = 1'b1;

  // sau_control bit positions
  localparam int CTRL_ENABLE = 0;
  localparam int CTRL_ALLNS  = 1;

  // controller -> datapath
  typedef struct packed {
    logic addr_load;   // capture check address
    logic tbl_wr;      // write region entry
    logic scan_clr;    // restart region scan
    logic scan_step;   // advance to next region
    logic res_load;    // load result register
  } sau_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;   // attribute known this cycle
    logic res_free;    // result register can take a new item
  } sau_stat_t;

endpackage

`default_nettype wire

### hdl/sau_if.sv
// ----------------------------------------------------------------------------
// sau_in_if / sau_out_if
// Valid/ready channels of the security attribution unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface sau_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] address;
  logic [2:0]  region_index;
  logic [26:0] region_base;
  logic [26:0] region_limit;
  logic        region_enable;
  logic        region_nsc;

  modport source (
    output valid, req_type, address, region_index, region_base, region_limit,
           region_enable, region_nsc,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, region_index, region_base, region_limit,
           region_enable, region_nsc,
    output ready
  );
endinterface

interface sau_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] attribute;

  modport source (output valid, attribute, input ready);
  modport sink   (input valid, attribute, output ready);
endinterface

`default_nettype wire

### hdl/sau_ctrl.sv
// ----------------------------------------------------------------------------
// sau_ctrl
// Sequencer: accepts items, steps the region scan, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_ctrl
  import sau_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_req_type,
  output logic           in_ready,
  input  wire sau_stat_t stat,
  output sau_cmd_t       cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  assign in_ready = ready_r;

  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && ready_r) begin
          if (in_req_type == REQ_WRITE) begin
            cmd.tbl_wr = 1'b1;
          end else begin
            cmd.addr_load = 1'b1;
            cmd.scan_clr  = 1'b1;
            state_nxt     = ST_SCAN;
            ready_nxt     = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          if (stat.res_free) begin
            cmd.res_load = 1'b1;
            state_nxt    = ST_IDLE;
            ready_nxt    = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sau_dp.sv
// ----------------------------------------------------------------------------
// sau_dp
// Region table, config registers, one-region-per-cycle matcher, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_dp
  import sau_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // config
  input  wire logic                cfg_we,
  input  wire logic                cfg_idx,
  input  wire logic [CTRL_W-1:0]   cfg_wdata,
  // input payload
  input  wire logic [ADDR_W-1:0]   in_address,
  input  wire logic [IDX_IN_W-1:0] in_region_index,
  input  wire logic [FLD_W-1:0]    in_region_base,
  input  wire logic [FLD_W-1:0]    in_region_limit,
  input  wire logic                in_region_enable,
  input  wire logic                in_region_nsc,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ATTR_W-1:0]        out_attribute,
  // control
  input  wire sau_cmd_t            cmd,
  output sau_stat_t                stat
);

  localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

  logic                tz_r;
  logic [CTRL_W-1:0]   ctrl_r;

  logic [FLD_W-1:0]    base_r  [REGIONS];
  logic [FLD_W-1:0]    limit_r [REGIONS];
  logic                nsc_r   [REGIONS];
  logic [REGIONS-1:0]  en_r;

  logic [FLD_W-1:0]    addr_r;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic                valid_r;
  logic [ATTR_W-1:0]   attr_r;

  logic                hit;
  logic                bypass;
  logic [ATTR_W-1:0]   attr_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r   <= 1'b0;
      ctrl_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_TZ) begin
        tz_r <= cfg_wdata[0];
      end else begin
        ctrl_r <= cfg_wdata;
      end
    end
  end

  // region table; only the enable bits need a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else begin
      for (int r = 0; r < REGIONS; r++) begin
        if (cmd.tbl_wr && (32'(in_region_index) == 32'(r))) begin
          en_r[r] <= in_region_enable;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < REGIONS; r++) begin
      if (cmd.tbl_wr && (32'(in_region_index) == 32'(r))) begin
        base_r[r]  <= in_region_base;
        limit_r[r] <= in_region_limit;
        nsc_r[r]   <= in_region_nsc;
      end
    end
  end

  // scan position and captured address (granule number)
  always_comb begin
    scan_nxt = scan_r;
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.scan_step) begin
      scan_nxt = scan_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (cmd.addr_load) begin
      addr_r <= in_address[ADDR_W-1:GRAN_BITS];
    end
  end

  // low 5 bits of base are zero and of limit all ones, so the range test
  // reduces to a granule compare
  assign hit = en_r[scan_r] && (addr_r >= base_r[scan_r])
                            && (addr_r <= limit_r[scan_r]);
  assign bypass = !tz_r || !ctrl_r[CTRL_ENABLE];

  always_comb begin
    if (!tz_r) begin
      attr_nxt = ATTR_SECURE;
    end else if (!ctrl_r[CTRL_ENABLE]) begin
      attr_nxt = ctrl_r[CTRL_ALLNS] ? ATTR_NONSECURE : ATTR_SECURE;
    end else if (hit) begin
      attr_nxt = nsc_r[scan_r] ? ATTR_NSC : ATTR_NONSECURE;
    end else begin
      attr_nxt = ATTR_SECURE;
    end
  end

  assign stat.scan_done = bypass || hit || (scan_r == LAST_IDX);
  assign stat.res_free  = !valid_r || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      attr_r <= attr_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_attribute = attr_r;

endmodule

`default_nettype wire

### hdl/sau_security_attribution_unit.sv
// ----------------------------------------------------------------------------
// sau_security_attribution_unit
// Security attribution unit: attributes byte addresses as secure,
// non-secure or non-secure callable from a table of regions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   valid/ready item channel. req_type = write loads region entry
//           region_index (ignored when not below REGIONS) and gives no
//           result; req_type = check looks up address and gives one item
//           on out_ch (attribute: 0 secure, 1 non-secure, 2 NSC).
//   cfg_*   write-only register port, taken whenever cfg_we is high:
//           index 0 trustzone_present, index 1 sau_control.
//   Timing: a write item is taken in the idle state, and the next item
//           can follow it directly. A check item is accepted, then the
//           shared range comparator visits one region per cycle until the
//           first enabled match or the last region; with TrustZone absent
//           or the unit disabled the answer comes on the first scan cycle.
//           No new item is taken while a check scans; the next item is
//           taken the cycle after the result is loaded.
//   Stall:  the result sits in an output register; the next item is taken
//           while it waits, and its scan holds at the end until the slot
//           frees.
//   Reset:  synchronous rst_n clears both config registers, the valid flag
//           and all region enable bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_security_attribution_unit
  import sau_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  sau_in_if.sink                 in_ch,
  sau_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [CTRL_W-1:0] cfg_wdata
);

  sau_cmd_t  cmd;
  sau_stat_t stat;

  // sequencer: owns in_ch.ready and the scan/result commands
  sau_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // table, matcher and result register
  sau_dp #(
    .REGIONS (REGIONS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_address       (in_ch.address),
    .in_region_index  (in_ch.region_index),
    .in_region_base   (in_ch.region_base),
    .in_region_limit  (in_ch.region_limit),
    .in_region_enable (in_ch.region_enable),
    .in_region_nsc    (in_ch.region_nsc),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_attribute    (out_ch.attribute),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

`default_nettype wire
